@@ src/ztt_pkg.sv @@
// ----------------------------------------------------------------------------
// ztt_pkg
// Shared types, command codes and default sizes of the Zobrist-hashed
// transposition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ztt_pkg;

  localparam int GRID_SIZE_DEF   = 15;
  localparam int INDEX_BITS_DEF  = 12;
  localparam int TABLE_COUNT_DEF = 2;

  localparam int SLOT_OUT_W = 12;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_CLEAR  = 3'd1;
  localparam logic [2:0] CMD_TOGGLE = 3'd2;
  localparam logic [2:0] CMD_PROBE  = 3'd3;
  localparam logic [2:0] CMD_STORE  = 3'd4;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               color;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [31:0]        index_key_word;
    logic [63:0]        sig_key_word;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [7:0]         depth;
    logic signed [15:0] eval;
    logic [1:0]         bound_kind;
    logic               table_sel;
  } ztt_in_t;

  typedef struct packed {
    logic                  hit;
    logic signed [15:0]    value;
    logic [SLOT_OUT_W-1:0] slot_index;
  } ztt_out_t;

  typedef struct packed {
    logic [1:0]         bound_kind;
    logic [7:0]         depth;
    logic signed [15:0] eval;
  } ztt_info_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } ztt_mem_req_t;

endpackage

@@ src/ztt_key_store.sv @@
// ----------------------------------------------------------------------------
// ztt_key_store
// Memory of the loaded index and signature keys, one pair per colour and
// cell; one shared port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztt_key_store import ztt_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF,
  parameter int KEY_COUNT = 2 * GRID_SIZE * GRID_SIZE,
  parameter int KEY_AW    = $clog2(KEY_COUNT)
) (
  input  logic              clk,
  input  ztt_mem_req_t      req,
  input  logic [KEY_AW-1:0] addr,
  input  logic [31:0]       wr_idx_key,
  input  logic [63:0]       wr_sig_key,
  output logic [31:0]       rd_idx_key,
  output logic [63:0]       rd_sig_key
);

  logic [95:0] key_mem_r [KEY_COUNT];
  logic [95:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      key_mem_r[addr] <= {wr_idx_key, wr_sig_key};
    end
    if (req.rd) begin
      rd_data_r <= key_mem_r[addr];
    end
  end

  assign rd_idx_key = rd_data_r[95:64];
  assign rd_sig_key = rd_data_r[63:0];

endmodule

@@ src/ztt_entry_store.sv @@
// ----------------------------------------------------------------------------
// ztt_entry_store
// Transposition entry memory: signature, info word and valid bit per slot.
// Sweeps every entry to invalid after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztt_entry_store import ztt_pkg::*; #(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int TABLE_COUNT = TABLE_COUNT_DEF,
  parameter int ENTRY_COUNT = TABLE_COUNT << INDEX_BITS,
  parameter int ENTRY_AW    = $clog2(ENTRY_COUNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ztt_mem_req_t        req,
  input  logic [ENTRY_AW-1:0] addr,
  input  logic [63:0]         wr_sig,
  input  ztt_info_t           wr_info,
  output logic [63:0]         rd_sig,
  output ztt_info_t           rd_info,
  output logic                rd_valid,
  output logic                clr_busy
);

  localparam int ENTRY_W = 64 + $bits(ztt_info_t) + 1;

  logic [ENTRY_W-1:0] ent_mem_r [ENTRY_COUNT];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_AW:0]  clr_cnt_r;
  logic [ENTRY_AW:0]  clr_cnt_nxt;

  assign clr_busy    = !clr_cnt_r[ENTRY_AW];
  assign clr_cnt_nxt = clr_busy ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      ent_mem_r[clr_cnt_r[ENTRY_AW-1:0]] <= '0;
    end else if (req.wr) begin
      ent_mem_r[addr] <= {wr_sig, wr_info, 1'b1};
    end
    if (req.rd) begin
      rd_data_r <= ent_mem_r[addr];
    end
  end

  assign rd_sig   = rd_data_r[ENTRY_W-1 -: 64];
  assign rd_info  = rd_data_r[$bits(ztt_info_t):1];
  assign rd_valid = rd_data_r[0];

endmodule

@@ src/zobrist_transposition_table_unit.sv @@
// ----------------------------------------------------------------------------
// zobrist_transposition_table_unit
// Zobrist-hashed transposition table: key memory, running keys, entry memory.
//
//   channel  | ports                      | moves
//   ---------+----------------------------+------------------------------
//   input    | in_valid, in_stall, in_data | one command transaction
//   result   | out_valid, out_stall, out_data | hit, value, slot index
//
// Each transaction is accepted in ST_IDLE, where the accept cycle issues the
// registered memory read (key memory for toggle, entry memory for probe);
// ST_EXEC then evaluates it and loads the output register.
// After reset in_stall stays high while the entry memory is swept to invalid,
// all TABLE_COUNT * 2^INDEX_BITS entries (8192 by default).
// A held result in the output register stalls only the evaluation cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zobrist_transposition_table_unit import ztt_pkg::*; #(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ztt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ztt_out_t out_data
);

  localparam int CELL_COUNT  = GRID_SIZE * GRID_SIZE;
  localparam int KEY_COUNT   = 2 * CELL_COUNT;
  localparam int KEY_AW      = $clog2(KEY_COUNT);
  localparam int ENTRY_COUNT = TABLE_COUNT << INDEX_BITS;
  localparam int ENTRY_AW    = $clog2(ENTRY_COUNT);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic        state_r, state_nxt;
  ztt_in_t     item_r;
  logic [31:0] run_idx_r, run_idx_nxt;
  logic [63:0] run_sig_r, run_sig_nxt;
  ztt_out_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic                  accept;
  logic                  fire;
  logic                  clr_busy;
  logic                  in_cell_ok;
  logic                  item_cell_ok;
  logic                  in_tsel_ok;
  logic                  item_tsel_ok;
  logic [KEY_AW-1:0]     key_addr;
  logic [INDEX_BITS:0]   ent_addr_full;
  logic [ENTRY_AW-1:0]   ent_addr;
  ztt_mem_req_t          key_req;
  ztt_mem_req_t          ent_req;
  logic [31:0]           key_idx_rd;
  logic [63:0]           key_sig_rd;
  logic [63:0]           ent_sig_rd;
  ztt_info_t             ent_info_rd;
  logic                  ent_valid_rd;
  ztt_info_t             ent_info_wr;
  logic                  ent_match;
  logic                  bound_use;

  assign in_stall = (state_r != ST_IDLE) || clr_busy;
  assign accept   = in_valid && !in_stall;
  assign fire     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  assign in_cell_ok   = (int'(in_data.row) < GRID_SIZE) && (int'(in_data.col) < GRID_SIZE);
  assign item_cell_ok = (int'(item_r.row) < GRID_SIZE) && (int'(item_r.col) < GRID_SIZE);
  assign in_tsel_ok   = int'(in_data.table_sel) < TABLE_COUNT;
  assign item_tsel_ok = int'(item_r.table_sel) < TABLE_COUNT;

  assign key_addr = (in_data.color ? KEY_AW'(CELL_COUNT) : '0)
                  + KEY_AW'(in_data.row) * KEY_AW'(GRID_SIZE)
                  + KEY_AW'(in_data.col);

  assign ent_addr_full = {in_data.table_sel, run_idx_r[INDEX_BITS-1:0]};
  assign ent_addr      = ent_addr_full[ENTRY_AW-1:0];

  assign key_req.rd = accept && (in_data.cmd == CMD_TOGGLE) && in_cell_ok;
  assign key_req.wr = accept && (in_data.cmd == CMD_LOAD) && in_cell_ok;
  assign ent_req.rd = accept && (in_data.cmd == CMD_PROBE) && in_tsel_ok;
  assign ent_req.wr = accept && (in_data.cmd == CMD_STORE) && in_tsel_ok;

  assign ent_info_wr.bound_kind = in_data.bound_kind;
  assign ent_info_wr.depth      = in_data.depth;
  assign ent_info_wr.eval       = in_data.eval;

  ztt_key_store #(
    .GRID_SIZE (GRID_SIZE)
  ) u_key_store (
    .clk        (clk),
    .req        (key_req),
    .addr       (key_addr),
    .wr_idx_key (in_data.index_key_word),
    .wr_sig_key (in_data.sig_key_word),
    .rd_idx_key (key_idx_rd),
    .rd_sig_key (key_sig_rd)
  );

  ztt_entry_store #(
    .INDEX_BITS  (INDEX_BITS),
    .TABLE_COUNT (TABLE_COUNT)
  ) u_entry_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (ent_req),
    .addr     (ent_addr),
    .wr_sig   (run_sig_r),
    .wr_info  (ent_info_wr),
    .rd_sig   (ent_sig_rd),
    .rd_info  (ent_info_rd),
    .rd_valid (ent_valid_rd),
    .clr_busy (clr_busy)
  );

  assign ent_match = item_tsel_ok && ent_valid_rd
                  && (ent_info_rd.depth >= item_r.depth)
                  && (ent_sig_rd == run_sig_r);

  always_comb begin
    case (ent_info_rd.bound_kind)
      BOUND_EXACT: bound_use = 1'b1;
      BOUND_LOWER: bound_use = ent_info_rd.eval >= item_r.beta;
      BOUND_UPPER: bound_use = ent_info_rd.eval <= item_r.alpha;
      default:     bound_use = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    run_idx_nxt   = run_idx_r;
    run_sig_nxt   = run_sig_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (accept) begin
      state_nxt = ST_EXEC;
      if (in_data.cmd == CMD_CLEAR) begin
        run_idx_nxt = '0;
        run_sig_nxt = '0;
      end
    end

    if (fire) begin
      state_nxt = ST_IDLE;
      if ((item_r.cmd == CMD_TOGGLE) && item_cell_ok) begin
        run_idx_nxt = run_idx_r ^ key_idx_rd;
        run_sig_nxt = run_sig_r ^ key_sig_rd;
      end
      out_nxt.hit   = 1'b0;
      out_nxt.value = '0;
      if ((item_r.cmd == CMD_PROBE) && ent_match && bound_use) begin
        out_nxt.hit   = 1'b1;
        out_nxt.value = ent_info_rd.eval;
      end
      out_nxt.slot_index = SLOT_OUT_W'(run_idx_nxt[INDEX_BITS-1:0]);
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_idx_r   <= '0;
      run_sig_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_idx_r   <= run_idx_nxt;
      run_sig_r   <= run_sig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/sv/ztt_checker.sv @@
// ----------------------------------------------------------------------------
// ztt_checker
// Watches both channels of the transposition table unit. Each accepted
// command is run through a cycle-free model of the key stores, running keys
// and entry tables. Each accepted result is compared field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztt_checker import ztt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  ztt_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  ztt_out_t out_data,
  output int       errors,
  output int       pending,
  output int       hits
);

  localparam int CELLS   = GRID_SIZE_DEF * GRID_SIZE_DEF;
  localparam int SLOTS   = 1 << INDEX_BITS_DEF;
  localparam int ENTRIES = TABLE_COUNT_DEF * SLOTS;

  logic [31:0] index_keys  [2*CELLS];
  logic [63:0] sig_keys    [2*CELLS];
  logic [31:0] run_index_key;
  logic [63:0] run_sig_key;
  logic [63:0] entry_sig   [ENTRIES];
  ztt_info_t   entry_info  [ENTRIES];
  bit          entry_valid [ENTRIES];
  ztt_out_t    probe_results[$];

  function automatic ztt_out_t execute_command(input ztt_in_t t);
    ztt_out_t           r;
    int                 cell_idx;
    int                 ent;
    bit                 on_board;
    logic signed [15:0] ev;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    r        = '0;
    on_board = (t.row < GRID_SIZE_DEF) && (t.col < GRID_SIZE_DEF);
    cell_idx = int'(t.color) * CELLS + int'(t.row) * GRID_SIZE_DEF + int'(t.col);
    ent      = int'(t.table_sel) * SLOTS + int'(run_index_key[INDEX_BITS_DEF-1:0]);
    lo       = t.alpha;
    hi       = t.beta;
    case (t.cmd)
      CMD_LOAD: begin
        if (on_board) begin
          index_keys[cell_idx] = t.index_key_word;
          sig_keys[cell_idx]   = t.sig_key_word;
        end
      end
      CMD_CLEAR: begin
        run_index_key = '0;
        run_sig_key   = '0;
      end
      CMD_TOGGLE: begin
        if (on_board) begin
          run_index_key ^= index_keys[cell_idx];
          run_sig_key   ^= sig_keys[cell_idx];
        end
      end
      CMD_PROBE: begin
        if (entry_valid[ent] && entry_info[ent].depth >= t.depth &&
            entry_sig[ent] == run_sig_key) begin
          ev = entry_info[ent].eval;
          case (entry_info[ent].bound_kind)
            BOUND_EXACT: r.hit = 1'b1;
            BOUND_LOWER: r.hit = (ev >= hi);
            BOUND_UPPER: r.hit = (ev <= lo);
            default:     r.hit = 1'b0;
          endcase
          if (r.hit) r.value = ev;
        end
      end
      CMD_STORE: begin
        entry_sig[ent]              = run_sig_key;
        entry_info[ent].eval        = t.eval;
        entry_info[ent].depth       = t.depth;
        entry_info[ent].bound_kind  = t.bound_kind;
        entry_valid[ent]            = 1'b1;
      end
      default: ;
    endcase
    r.slot_index = run_index_key[SLOT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    ztt_out_t want;
    if (!rst_n) begin
      run_index_key = '0;
      run_sig_key   = '0;
      foreach (entry_valid[i]) entry_valid[i] = 1'b0;
      probe_results.delete();
    end else begin
      if (in_valid && !in_stall) probe_results.push_back(execute_command(in_data));
      if (out_valid && !out_stall) begin
        if (probe_results.size() == 0) begin
          errors++;
          $error("unexpected result transaction: hit=%0d value=%0d slot_index=%0d",
                 out_data.hit, $signed(out_data.value), out_data.slot_index);
        end else begin
          want = probe_results.pop_front();
          if (out_data.hit) hits++;
          if (out_data.hit !== want.hit) begin
            errors++;
            $error("hit: expected %0d, actual %0d", want.hit, out_data.hit);
          end
          if (out_data.value !== want.value) begin
            errors++;
            $error("value: expected %0d, actual %0d", $signed(want.value),
                   $signed(out_data.value));
          end
          if (out_data.slot_index !== want.slot_index) begin
            errors++;
            $error("slot_index: expected %0d, actual %0d", want.slot_index,
                   out_data.slot_index);
          end
        end
      end
    end
    pending = probe_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the transposition table unit. A short directed
// pass hits the window extremes, every bound rule and the ignored cases; the
// random pass plays positions (load keys, toggle stones, store, probe back)
// mixed with stray commands, under random idling and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ztt_pkg::*;

  localparam int CELLS        = GRID_SIZE_DEF * GRID_SIZE_DEF;
  localparam int SLOTS        = 1 << INDEX_BITS_DEF;
  localparam int ITEM_TARGET  = 1850;
  localparam int QUIET_SPAN   = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [1:0] BOUND_UNKNOWN = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_stall = 1'b0;
  ztt_in_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  ztt_out_t out_data;
  int       errors;
  int       pending;
  int       hits;
  int       cycle_count = 0;

  logic [31:0] key_shadow [2*CELLS];
  bit          key_loaded [2*CELLS];
  int          loaded_cells[$];
  logic [31:0] run_key_shadow = '0;
  bit          slot_written [2][SLOTS];
  int          cmd_count [8];
  int          sent = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_gaps = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  zobrist_transposition_table_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ztt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .hits      (hits)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int cell_of(input logic color, input logic [3:0] row,
                                 input logic [3:0] col);
    return int'(color) * CELLS + int'(row) * GRID_SIZE_DEF + int'(col);
  endfunction

  function automatic bit on_board(input ztt_in_t t);
    return (t.row < GRID_SIZE_DEF) && (t.col < GRID_SIZE_DEF);
  endfunction

  function automatic ztt_in_t rand_fields();
    logic [191:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(ztt_in_t)-1:0];
  endfunction

  function automatic ztt_in_t place(input ztt_in_t t, input int c);
    logic [31:0] r;
    logic [31:0] k;
    r       = (c % CELLS) / GRID_SIZE_DEF;
    k       = (c % CELLS) % GRID_SIZE_DEF;
    t.color = (c >= CELLS);
    t.row   = r[3:0];
    t.col   = k[3:0];
    return t;
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    logic [31:0] w;
    w = v;
    if (v > 32767) w = 32767;
    if (v < -32768) w = -32768;
    return w[15:0];
  endfunction

  // track what the block will hold so that only legal toggles and probes go out
  function automatic void note_command(input ztt_in_t t);
    int c;
    c = cell_of(t.color, t.row, t.col);
    cmd_count[t.cmd]++;
    case (t.cmd)
      CMD_LOAD: begin
        if (on_board(t)) begin
          key_shadow[c] = t.index_key_word;
          if (!key_loaded[c]) loaded_cells.push_back(c);
          key_loaded[c] = 1'b1;
        end
      end
      CMD_CLEAR:  run_key_shadow = '0;
      CMD_TOGGLE: if (on_board(t)) run_key_shadow ^= key_shadow[c];
      CMD_STORE:  slot_written[t.table_sel][run_key_shadow[INDEX_BITS_DEF-1:0]] = 1'b1;
      default: ;
    endcase
  endfunction

  task automatic send(input ztt_in_t t);
    int gap;
    note_command(t);
    if (sent % 100 == 0) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
    end
    if (sent == HOLD_AT) hold_req = 1'b1;
    if (sent >= ITEM_TARGET - QUIET_SPAN) quiet = 1'b1;
    sent++;
    if (tx_gaps && !quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic key_op(input logic [2:0] cmd, input int c, input logic [31:0] ik,
                        input logic [63:0] sk);
    ztt_in_t t;
    t                = place(rand_fields(), c);
    t.cmd            = cmd;
    t.index_key_word = ik;
    t.sig_key_word   = sk;
    send(t);
  endtask

  task automatic entry_op(input logic [2:0] cmd, input logic tsel, input logic [1:0] kind,
                          input logic [7:0] dep, input logic [15:0] ev,
                          input logic [15:0] lo, input logic [15:0] hi);
    ztt_in_t t;
    t            = rand_fields();
    t.cmd        = cmd;
    t.table_sel  = tsel;
    t.bound_kind = kind;
    t.depth      = dep;
    t.eval       = ev;
    t.alpha      = lo;
    t.beta       = hi;
    send(t);
  endtask

  task automatic load_key();
    ztt_in_t t;
    t     = place(rand_fields(), $urandom_range(0, 2*CELLS-1));
    t.cmd = CMD_LOAD;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) != 0) t.row = 4'd15;
      else t.col = 4'd15;
    end
    // keep the slot, change only the signature
    if ($urandom_range(0, 3) == 0) t.index_key_word[INDEX_BITS_DEF-1:0] = '0;
    send(t);
  endtask

  task automatic toggle_stone(output int c);
    ztt_in_t t;
    t     = rand_fields();
    t.cmd = CMD_TOGGLE;
    c     = -1;
    if (loaded_cells.size() == 0) begin
      load_key();
    end else if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) != 0) t.row = 4'd15;
      else t.col = 4'd15;
      send(t);
    end else begin
      c = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
      send(place(t, c));
    end
  endtask

  task automatic toggle_back(input int c);
    ztt_in_t t;
    if (c >= 0) begin
      t     = rand_fields();
      t.cmd = CMD_TOGGLE;
      send(place(t, c));
    end
  endtask

  // never probe an entry that was not stored: switch tables or store instead
  task automatic probe_table(input ztt_in_t t);
    logic [INDEX_BITS_DEF-1:0] slot;
    slot = run_key_shadow[INDEX_BITS_DEF-1:0];
    if (!slot_written[t.table_sel][slot]) t.table_sel = ~t.table_sel;
    if (!slot_written[t.table_sel][slot]) t.cmd = CMD_STORE;
    send(t);
  endtask

  task automatic play_position();
    ztt_in_t     st;
    ztt_in_t     pr;
    ztt_in_t     t;
    int          c;
    int          ev;
    int          off;
    logic [31:0] pick;
    if ($urandom_range(0, 7) == 0) begin
      t     = rand_fields();
      t.cmd = CMD_CLEAR;
      send(t);
    end
    if (loaded_cells.size() < 60 || $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) load_key();
    repeat ($urandom_range(0, 4)) toggle_stone(c);
    st     = rand_fields();
    st.cmd = CMD_STORE;
    pick   = $urandom_range(0, 2);
    if ($urandom_range(0, 9) != 0) st.bound_kind = pick[1:0];
    if ($urandom_range(0, 9) == 0) st.eval = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    send(st);
    if ($urandom_range(0, 2) == 0) begin
      toggle_stone(c);
      if ($urandom_range(0, 3) != 0) toggle_back(c);
    end
    pr     = rand_fields();
    pr.cmd = CMD_PROBE;
    if ($urandom_range(0, 7) != 0) pr.table_sel = st.table_sel;
    if ($urandom_range(0, 7) != 0) begin
      pick     = $urandom_range(0, st.depth);
      pr.depth = pick[7:0];
    end
    if ($urandom_range(0, 3) != 0) begin
      ev       = $signed(st.eval);
      off      = $urandom_range(0, 8);
      pr.alpha = clamp16(ev + off - 4);
      off      = $urandom_range(0, 8);
      pr.beta  = clamp16(ev + off - 4);
    end
    probe_table(pr);
    if ($urandom_range(0, 2) == 0) begin
      t        = rand_fields();
      pr.alpha = t.alpha;
      pr.beta  = t.beta;
      probe_table(pr);
    end
  endtask

  task automatic stray_command();
    ztt_in_t t;
    int      c;
    t = rand_fields();
    if (t.cmd == CMD_TOGGLE) toggle_stone(c);
    else if (t.cmd == CMD_PROBE) probe_table(t);
    else send(t);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    ztt_in_t    t;
    logic [2:0] code;
    int         spare;
    int         c;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    key_op(CMD_LOAD, cell_of(1'b0, 4'd0, 4'd0), 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    key_op(CMD_LOAD, cell_of(1'b1, 4'd14, 4'd14), 32'h1234_5000, 64'h8000_0000_0000_0001);
    t     = rand_fields();
    t.cmd = CMD_LOAD;
    t.row = 4'd15;
    send(t);
    t     = rand_fields();
    t.cmd = CMD_LOAD;
    t.row = 4'd2;
    t.col = 4'd15;
    send(t);
    key_op(CMD_TOGGLE, cell_of(1'b0, 4'd0, 4'd0), '0, '0);
    entry_op(CMD_STORE, 1'b0, BOUND_EXACT, 8'd255, 16'sh7FFF, '0, '0);
    entry_op(CMD_PROBE, 1'b0, BOUND_EXACT, 8'd255, '0, '0, '0);
    key_op(CMD_TOGGLE, cell_of(1'b1, 4'd14, 4'd14), '0, '0);
    entry_op(CMD_PROBE, 1'b0, BOUND_EXACT, 8'd0, '0, '0, '0);
    entry_op(CMD_STORE, 1'b1, BOUND_LOWER, 8'd0, 16'sh8000, '0, '0);
    entry_op(CMD_PROBE, 1'b1, BOUND_EXACT, 8'd0, '0, 16'sh7FFF, 16'sh8000);
    entry_op(CMD_PROBE, 1'b1, BOUND_EXACT, 8'd0, '0, 16'sh7FFF, 16'sh7FFF);
    entry_op(CMD_STORE, 1'b1, BOUND_UPPER, 8'd0, 16'sh7FFF, '0, '0);
    entry_op(CMD_PROBE, 1'b1, BOUND_EXACT, 8'd0, '0, 16'sh7FFF, 16'sh8000);
    entry_op(CMD_PROBE, 1'b1, BOUND_EXACT, 8'd0, '0, 16'sh8000, 16'sh8000);
    entry_op(CMD_PROBE, 1'b1, BOUND_EXACT, 8'd1, '0, 16'sh7FFF, 16'sh8000);
    entry_op(CMD_STORE, 1'b1, BOUND_UNKNOWN, 8'd9, 16'sd5, '0, '0);
    entry_op(CMD_PROBE, 1'b1, BOUND_EXACT, 8'd0, '0, 16'sh7FFF, 16'sh8000);
    code = CMD_STORE;
    repeat (3) begin
      code++;
      t     = rand_fields();
      t.cmd = code;
      send(t);
    end
    t     = rand_fields();
    t.cmd = CMD_TOGGLE;
    t.row = 4'd15;
    t.col = 4'd15;
    send(t);
    t     = rand_fields();
    t.cmd = CMD_CLEAR;
    send(t);
    entry_op(CMD_STORE, 1'b0, BOUND_EXACT, 8'd128, 16'shFFFF, '0, '0);
    entry_op(CMD_PROBE, 1'b0, BOUND_EXACT, 8'd128, '0, '0, '0);

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) stray_command();
      else play_position();
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    spare = 0;
    for (int k = CMD_STORE + 1; k < 8; k++) spare += cmd_count[k];
    c = loaded_cells.size();
    $display("Sent %0d transactions: %0d loads, %0d clears, %0d toggles, %0d stores,",
             sent, cmd_count[CMD_LOAD], cmd_count[CMD_CLEAR], cmd_count[CMD_TOGGLE],
             cmd_count[CMD_STORE]);
    $display("%0d probes with %0d hits, %0d spare codes, %0d cells keyed",
             cmd_count[CMD_PROBE], hits, spare, c);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ zobrist_transposition_table_unit.f @@
src/ztt_pkg.sv
src/ztt_key_store.sv
src/ztt_entry_store.sv
src/zobrist_transposition_table_unit.sv
tb/sv/ztt_checker.sv
tb/sv/tb.sv
